// ===== design/p7u_pkg.sv =====
// ----------------------------------------------------------------------------
// p7u_pkg
// Shared types, sizes, status codes and the controller/datapath command and
// status structs for the padding-removal stream core.
// ----------------------------------------------------------------------------
package p7u_pkg;

    localparam int MAX_BLOCK = 32;
    localparam int IDX_W     = $clog2(MAX_BLOCK);
    localparam int BS_W      = 6;

    typedef logic [7:0]       byte_t;
    typedef logic [1:0]       stat_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [BS_W-1:0]  bsize_t;

    localparam bsize_t BS_RESET = 6'd16;
    localparam bsize_t BS_MIN   = 6'd2;
    localparam bsize_t BS_MAX   = BS_W'(MAX_BLOCK);

    // Closing status codes
    localparam stat_t ST_OK         = 2'd0;
    localparam stat_t ST_INCOMPLETE = 2'd1;
    localparam stat_t ST_BAD_COUNT  = 2'd2;
    localparam stat_t ST_BAD_PAD    = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic  take;       // accept input beat: store byte, read held byte
        logic  rd;         // read store at sweep index
        logic  ld_data;    // load output register with read data
        logic  ld_stat;    // load output register with status, end stream
        logic  init_tail;  // sweep the unreleased rest of the held block
        logic  init_chk;   // sweep the pad bytes
        logic  init_keep;  // sweep the kept bytes of the final block
        logic  inc;        // advance sweep index
        logic  st_we;      // write status register
        stat_t st_val;
    } p7u_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic prev_valid;
        logic fin;
        logic out_free;
        logic incomplete;
        logic bad_count;
        logic idx_last;
        logic pad_mismatch;
        logic keep_zero;
    } p7u_sts_t;

endpackage

// ===== design/p7u_if.sv =====
// ----------------------------------------------------------------------------
// p7u channel interfaces
// Valid/ready channels for input bytes, result beats and the block-size write.
// ----------------------------------------------------------------------------
interface p7u_in_if;
    import p7u_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  is_final;

    modport source (output valid, output data_byte, output is_final, input ready);
    modport sink   (input valid, input data_byte, input is_final, output ready);
endinterface

interface p7u_out_if;
    import p7u_pkg::*;

    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  end_mark;
    stat_t status;

    modport source (output valid, output out_byte, output end_mark, output status,
                    input ready);
    modport sink   (input valid, input out_byte, input end_mark, input status,
                    output ready);
endinterface

interface p7u_cfg_if;
    import p7u_pkg::*;

    logic   valid;
    logic   ready;
    bsize_t block_size;

    modport source (output valid, output block_size, input ready);
    modport sink   (input valid, input block_size, output ready);
endinterface

// ===== design/p7u_datapath.sv =====
// ----------------------------------------------------------------------------
// p7u_datapath
// Block store (delay line), stream position, sweep index, pad checks and the
// output register.
// ----------------------------------------------------------------------------
module p7u_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  p7u_pkg::p7u_cmd_t cmd,
    output p7u_pkg::p7u_sts_t sts,
    input  logic              cfg_we,
    input  p7u_pkg::bsize_t   cfg_size,
    input  p7u_pkg::byte_t    in_byte,
    input  logic              in_final,
    input  logic              out_ready,
    output logic              out_valid,
    output p7u_pkg::byte_t    out_byte,
    output logic              out_end,
    output p7u_pkg::stat_t    out_status
);
    import p7u_pkg::*;

    byte_t  mem [MAX_BLOCK];
    byte_t  rd_data_reg;

    bsize_t bs_reg, bs_next;
    idx_t   pos_reg, pos_next;
    logic   prev_reg, prev_next;
    logic   fin_reg;
    byte_t  pad_reg;
    idx_t   idx_reg;
    idx_t   last_reg;
    stat_t  st_reg;

    logic   out_valid_reg;
    byte_t  out_byte_reg;
    logic   out_end_reg;
    stat_t  out_status_reg;

    bsize_t bs_eff;
    idx_t   pos_eff;
    bsize_t pos_inc;
    bsize_t keep;
    bsize_t bs_m1;
    bsize_t keep_m1;

    // Clamp block size and position
    always_comb
    begin
        if (bs_reg < BS_MIN)
            bs_eff = BS_MIN;
        else if (bs_reg > BS_MAX)
            bs_eff = BS_MAX;
        else
            bs_eff = bs_reg;
        pos_eff = ({1'b0, pos_reg} >= bs_eff) ? '0 : pos_reg;
        pos_inc = {1'b0, pos_eff} + bsize_t'(1);
        keep    = bs_eff - bsize_t'(pad_reg);
        bs_m1   = bs_eff - bsize_t'(1);
        keep_m1 = keep - bsize_t'(1);
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mem[pos_eff] <= in_byte;
            rd_data_reg  <= mem[pos_eff];
        end
        else if (cmd.rd)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    // Next stream position and held-block flag
    always_comb
    begin
        bs_next   = bs_reg;
        pos_next  = pos_reg;
        prev_next = prev_reg;
        if (cfg_we)
        begin
            bs_next   = cfg_size;
            pos_next  = '0;
            prev_next = 1'b0;
        end
        else if (cmd.ld_stat)
        begin
            pos_next  = '0;
            prev_next = 1'b0;
        end
        else if (cmd.take && !in_final)
        begin
            if (pos_inc >= bs_eff)
            begin
                pos_next  = '0;
                prev_next = 1'b1;
            end
            else
            begin
                pos_next = pos_inc[IDX_W-1:0];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg        <= BS_RESET;
            pos_reg       <= '0;
            prev_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bs_reg   <= bs_next;
            pos_reg  <= pos_next;
            prev_reg <= prev_next;
            if (cmd.take)
                fin_reg <= in_final;
            if (cmd.ld_data || cmd.ld_stat)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Sweep index, pad count, status and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            pad_reg <= in_byte;
        if (cmd.init_tail)
        begin
            idx_reg  <= pos_inc[IDX_W-1:0];
            last_reg <= bs_m1[IDX_W-1:0];
        end
        else if (cmd.init_chk)
        begin
            idx_reg  <= keep[IDX_W-1:0];
            last_reg <= bs_m1[IDX_W-1:0];
        end
        else if (cmd.init_keep)
        begin
            idx_reg  <= '0;
            last_reg <= keep_m1[IDX_W-1:0];
        end
        else if (cmd.inc)
        begin
            idx_reg <= idx_reg + idx_t'(1);
        end
        if (cmd.st_we)
            st_reg <= cmd.st_val;
        if (cmd.ld_data)
        begin
            out_byte_reg   <= rd_data_reg;
            out_end_reg    <= 1'b0;
            out_status_reg <= ST_OK;
        end
        else if (cmd.ld_stat)
        begin
            out_byte_reg   <= '0;
            out_end_reg    <= 1'b1;
            out_status_reg <= st_reg;
        end
    end

    // Status toward the controller
    always_comb
    begin
        sts.prev_valid   = prev_reg;
        sts.fin          = fin_reg;
        sts.out_free     = !out_valid_reg || out_ready;
        sts.incomplete   = (pos_inc != bs_eff);
        sts.bad_count    = (pad_reg == '0) || (pad_reg > {2'b00, bs_eff});
        sts.idx_last     = (idx_reg == last_reg);
        sts.pad_mismatch = (rd_data_reg != pad_reg);
        sts.keep_zero    = (keep == '0);
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_end    = out_end_reg;
    assign out_status = out_status_reg;

endmodule

// ===== design/p7u_ctrl.sv =====
// ----------------------------------------------------------------------------
// p7u_ctrl
// Sequencer: accepts bytes, releases held bytes, and walks the final block
// for the tail flush, the pad check and the emit of kept bytes.
// ----------------------------------------------------------------------------
module p7u_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_final,
    input  p7u_pkg::p7u_sts_t sts,
    output p7u_pkg::p7u_cmd_t cmd
);
    import p7u_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_REL  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_TRD  = 3'd3;
    localparam logic [2:0] S_TOUT = 3'd4;
    localparam logic [2:0] S_CRD  = 3'd5;
    localparam logic [2:0] S_CCMP = 3'd6;
    localparam logic [2:0] S_STAT = 3'd7;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        cmd.st_val = ST_OK;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (sts.prev_valid)
                        state_next = S_REL;
                    else if (in_final)
                        state_next = S_FIN;
                end
            end
            // Release the held byte at the current position
            S_REL:
            begin
                if (sts.out_free)
                begin
                    cmd.ld_data = 1'b1;
                    state_next  = sts.fin ? S_FIN : S_IDLE;
                end
            end
            // Classify the final block
            S_FIN:
            begin
                cmd.st_we = 1'b1;
                if (sts.incomplete)
                begin
                    cmd.st_val = ST_INCOMPLETE;
                    if (sts.prev_valid)
                    begin
                        cmd.init_tail = 1'b1;
                        state_next    = S_TRD;
                    end
                    else
                    begin
                        state_next = S_STAT;
                    end
                end
                else if (sts.bad_count)
                begin
                    cmd.st_val = ST_BAD_COUNT;
                    state_next = S_STAT;
                end
                else
                begin
                    cmd.st_val    = ST_OK;
                    cmd.init_chk  = 1'b1;
                    state_next    = S_CRD;
                end
            end
            S_TRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_TOUT;
            end
            // Emit one swept byte
            S_TOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.ld_data = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = S_STAT;
                    end
                    else
                    begin
                        cmd.inc    = 1'b1;
                        state_next = S_TRD;
                    end
                end
            end
            S_CRD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CCMP;
            end
            // Compare one pad byte against the count
            S_CCMP:
            begin
                if (sts.pad_mismatch)
                begin
                    cmd.st_we  = 1'b1;
                    cmd.st_val = ST_BAD_PAD;
                    state_next = S_STAT;
                end
                else if (sts.idx_last)
                begin
                    if (sts.keep_zero)
                    begin
                        state_next = S_STAT;
                    end
                    else
                    begin
                        cmd.init_keep = 1'b1;
                        state_next    = S_TRD;
                    end
                end
                else
                begin
                    cmd.inc    = 1'b1;
                    state_next = S_CRD;
                end
            end
            // Close the stream with the status beat
            S_STAT:
            begin
                if (sts.out_free)
                begin
                    cmd.ld_stat = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/pkcs7_unpad_stream_core.sv =====
// ----------------------------------------------------------------------------
// pkcs7_unpad_stream_core
// Streaming PKCS#7 padding removal with a one-block delay line.
// ----------------------------------------------------------------------------
// Bytes enter one beat at a time, the last marked by is_final. Each byte is
// held for one cipher block and released when the byte at the same position
// of the next block arrives, so the final block is never emitted before it is
// checked. A byte with no held block is only stored; one that releases a held
// byte passes it through the registered store read and the output register.
// The final byte then leads to a classify state and, for a valid pad count or
// a short block with a held block, a walk through the single store read port,
// a read and an emit or compare per byte: the pad bytes, then if all match the
// kept bytes, or the unreleased tail of the held block when the final block
// is short. A status beat with end_mark high closes the stream. Result stalls
// hold the emits and the status beat. A block_size write (clamped to 2..32)
// clears the position and the held block but does not stop a walk under way.
module pkcs7_unpad_stream_core (
    input  logic clk,
    input  logic rst_n,
    p7u_in_if.sink    bytes,
    p7u_out_if.source results,
    p7u_cfg_if.sink   cfg
);
    import p7u_pkg::*;

    p7u_cmd_t cmd;
    p7u_sts_t sts;
    logic     in_ready;

    // Configuration writes are always taken
    assign cfg.ready   = 1'b1;
    assign bytes.ready = in_ready;

    p7u_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bytes.valid),
        .in_ready (in_ready),
        .in_final (bytes.is_final),
        .sts      (sts),
        .cmd      (cmd)
    );

    p7u_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg.valid),
        .cfg_size   (cfg.block_size),
        .in_byte    (bytes.data_byte),
        .in_final   (bytes.is_final),
        .out_ready  (results.ready),
        .out_valid  (results.valid),
        .out_byte   (results.out_byte),
        .out_end    (results.end_mark),
        .out_status (results.status)
    );

endmodule
